// ===== rtl/rslp_pkg.sv =====
// Shared types and constants of the sub key list cell parser.
package rslp_pkg;

   localparam int CellSizeWidth = 20;

   // Signature characters of the four list kinds.
   localparam logic [7:0] CharR = 8'h72;
   localparam logic [7:0] CharI = 8'h69;
   localparam logic [7:0] CharL = 8'h6c;
   localparam logic [7:0] CharF = 8'h66;
   localparam logic [7:0] CharH = 8'h68;

   typedef enum logic [2:0] {
      ST_ENTRY  = 3'd0,
      ST_EMPTY  = 3'd1,
      ST_BADSIG = 3'd2,
      ST_SHORT  = 3'd3,
      ST_COUNT  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'b001,
      PH_HEADER  = 3'b010,
      PH_ENTRIES = 3'b100
   } phase_type;

   typedef struct packed {
      logic [7:0]               data_byte;
      logic [CellSizeWidth-1:0] cell_size;
      logic                     first_byte;
      logic                     last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] subkey_offset;
      logic [31:0] name_hash;
      logic        has_hash;
      logic        leaf_level;
      status_type  status;
      logic        final_entry;
   } rsp_payload_type;

endpackage

// ===== rtl/rslp_ifs.sv =====
// Request and response channel interfaces of the sub key list cell parser.
interface rslp_req_if;
   import rslp_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [7:0]               data_byte;
   logic [CellSizeWidth-1:0] cell_size;
   logic                     first_byte;
   logic                     last_byte;

   modport source (output valid, data_byte, cell_size, first_byte, last_byte, input ready);
   modport sink   (input valid, data_byte, cell_size, first_byte, last_byte, output ready);
endinterface

interface rslp_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] subkey_offset;
   logic [31:0] name_hash;
   logic        has_hash;
   logic        leaf_level;
   logic [2:0]  status;
   logic        final_entry;

   modport source (output valid, subkey_offset, name_hash, has_hash, leaf_level, status,
                   final_entry, input ready);
   modport sink   (input valid, subkey_offset, name_hash, has_hash, leaf_level, status,
                   final_entry, output ready);
endinterface

// ===== rtl/registry_subkey_list_parser.sv =====
// Top level of the registry sub key list cell parser.
// This block takes a sub key list cell one byte per request, with the cell size on the byte
// marked as first, and returns one response per complete list element (key offset, and hash
// for lf and lh lists) or a single status response for an empty list, a bad signature, a
// short cell or an element count that cannot fit. It sustains one request per clock cycle
// while the skid register is free, and each response is registered before it is presented.
// Parsing state is updated by short logic at each accepted request and the response is held
// in an output register backed by one skid register, so request ready falls only while both
// are full. The old layout register is sampled on every first byte and should be written
// only between cells.
module registry_subkey_list_parser (
   input  logic      clock,
   input  logic      reset,
   rslp_req_if.sink  req_chan,
   rslp_rsp_if.source rsp_chan,
   input  logic      csr_write_en,
   input  logic      csr_write_data
);
   import rslp_pkg::*;

   logic            old_layout_ff;
   logic            accept;
   logic            res_valid;
   logic            has_space;
   req_payload_type req_data;
   rsp_payload_type res_data;
   rsp_payload_type out_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         old_layout_ff <= 1'b0;
      end else if (csr_write_en) begin
         old_layout_ff <= csr_write_data;
      end
   end

   // A request is taken whenever the skid register is free.
   assign req_chan.ready = has_space;
   assign accept         = req_chan.valid && has_space;

   assign req_data.data_byte  = req_chan.data_byte;
   assign req_data.cell_size  = req_chan.cell_size;
   assign req_data.first_byte = req_chan.first_byte;
   assign req_data.last_byte  = req_chan.last_byte;

   rslp_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req        (req_data),
      .old_layout (old_layout_ff),
      .res_valid  (res_valid),
      .res        (res_data)
   );

   rslp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res_data),
      .out_ready (rsp_chan.ready),
      .out_valid (rsp_chan.valid),
      .out_data  (out_data),
      .has_space (has_space)
   );

   assign rsp_chan.subkey_offset = out_data.subkey_offset;
   assign rsp_chan.name_hash     = out_data.name_hash;
   assign rsp_chan.has_hash      = out_data.has_hash;
   assign rsp_chan.leaf_level    = out_data.leaf_level;
   assign rsp_chan.status        = out_data.status;
   assign rsp_chan.final_entry   = out_data.final_entry;

`ifndef SYNTH
   // The skid register only fills behind an occupied output register.
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> rsp_chan.valid)
      else $error("skid register full while output register empty");

   // A response pushed into a stalled, occupied output register lands in the skid.
   a_skid_fills: assert property (@(posedge clock) disable iff (reset)
      (res_valid && rsp_chan.valid && !rsp_chan.ready) |=> !req_chan.ready)
      else $error("response lost while output stalled");

   // Status responses always close their cell.
   a_status_final: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res_data.status != ST_ENTRY) |-> res_data.final_entry)
      else $error("status response without final flag");

   // Nothing is presented straight after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("response valid after reset");
`endif

endmodule

// ===== rtl/rslp_parser.sv =====
// Per-byte cell parsing state and the logic that forms at most one response per request.
module rslp_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  rslp_pkg::req_payload_type req,
   input  logic                     old_layout,
   output logic                     res_valid,
   output rslp_pkg::rsp_payload_type res
);
   import rslp_pkg::*;

   phase_type                phase_ff, phase_in;
   logic [2:0]               pos_ff, pos_in;
   logic [CellSizeWidth-1:0] size_ff, size_in;
   logic                     layout_ff, layout_in;
   logic [7:0]               sig_ff, sig_in;
   logic                     wide_ff, wide_in;
   logic                     leaf_ff, leaf_in;
   logic [15:0]              left_ff, left_in;
   logic [63:0]              shift_ff, shift_in;

   logic                     done;
   logic [2:0]               pre;
   logic [2:0]               pos_cur;
   logic [3:0]               hdr;
   logic [3:0]               next_cnt;
   logic [3:0]               esize;
   logic [CellSizeWidth-1:0] diff;
   logic [CellSizeWidth-1:0] allowed;
   logic                     fin;

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      size_in   = size_ff;
      layout_in = layout_ff;
      sig_in    = sig_ff;
      wide_in   = wide_ff;
      leaf_in   = leaf_ff;
      left_in   = left_ff;
      shift_in  = shift_ff;
      done      = 1'b0;
      res_valid = 1'b0;
      res       = '0;
      res.status = ST_ENTRY;
      next_cnt  = '0;
      fin       = 1'b0;

      if (req.first_byte) begin
         phase_in  = PH_HEADER;
         pos_in    = '0;
         size_in   = req.cell_size;
         layout_in = old_layout;
         sig_in    = '0;
         wide_in   = 1'b0;
         leaf_in   = 1'b0;
         left_in   = '0;
         shift_in  = '0;
      end
      pre     = layout_in ? 3'd4 : 3'd0;
      hdr     = {1'b0, pre} + 4'd4;
      esize   = wide_in ? 4'd8 : 4'd4;
      diff    = size_in - {{(CellSizeWidth-4){1'b0}}, hdr};
      allowed = wide_in ? (diff >> 3) : (diff >> 2);
      // Header position seen by this byte: a first byte always starts at zero.
      pos_cur = pos_in;

      // A cell smaller than its own header is rejected on its first byte.
      if (req.first_byte && (req.cell_size < {{(CellSizeWidth-4){1'b0}}, hdr})) begin
         done       = 1'b1;
         res.status = ST_SHORT;
      end

      if (!done && phase_in == PH_HEADER) begin
         pos_in = pos_in + 3'd1;
         if (pos_cur < pre) begin
         end else if (pos_cur == pre) begin
            sig_in = req.data_byte;
         end else if (pos_cur == pre + 3'd1) begin
            if (sig_in == CharR && req.data_byte == CharI) begin
               wide_in = 1'b0;
               leaf_in = 1'b0;
            end else if (sig_in == CharL && req.data_byte == CharI) begin
               wide_in = 1'b0;
               leaf_in = 1'b1;
            end else if (sig_in == CharL &&
                         (req.data_byte == CharF || req.data_byte == CharH)) begin
               wide_in = 1'b1;
               leaf_in = 1'b1;
            end else begin
               done       = 1'b1;
               res.status = ST_BADSIG;
            end
         end else if (pos_cur == pre + 3'd2) begin
            left_in = {8'h00, req.data_byte};
         end else begin
            left_in = {req.data_byte, left_in[7:0]};
            if (left_in == 16'h0000) begin
               done       = 1'b1;
               res.status = ST_EMPTY;
            end else if ({{(CellSizeWidth-16){1'b0}}, left_in} > allowed) begin
               done       = 1'b1;
               res.status = ST_COUNT;
            end else begin
               phase_in = PH_ENTRIES;
               pos_in   = '0;
               shift_in = '0;
            end
         end
         if (!done && req.last_byte) begin
            done       = 1'b1;
            res.status = ST_SHORT;
         end
      end else if (!done && phase_in == PH_ENTRIES) begin
         shift_in[{pos_in, 3'b000} +: 8] = req.data_byte;
         next_cnt = {1'b0, pos_in} + 4'd1;
         pos_in   = next_cnt[2:0];
         fin      = (left_in <= 16'd1);
         if (next_cnt >= esize && (fin || !req.last_byte)) begin
            res_valid         = 1'b1;
            res.subkey_offset = shift_in[31:0];
            res.name_hash     = wide_in ? shift_in[63:32] : 32'h0;
            res.has_hash      = wide_in;
            res.leaf_level    = leaf_in;
            res.status        = ST_ENTRY;
            res.final_entry   = fin;
            left_in           = left_in - 16'd1;
            pos_in            = '0;
            shift_in          = '0;
            if (fin) begin
               phase_in = PH_IDLE;
            end
         end else if (req.last_byte) begin
            done       = 1'b1;
            res.status = ST_SHORT;
         end
      end

      // Any error verdict closes the cell with a single status response.
      if (done) begin
         phase_in          = PH_IDLE;
         res_valid         = 1'b1;
         res.subkey_offset = '0;
         res.name_hash     = '0;
         res.has_hash      = wide_in;
         res.leaf_level    = leaf_in;
         res.final_entry   = 1'b1;
      end
      if (!accept) begin
         res_valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         pos_ff    <= '0;
         size_ff   <= '0;
         layout_ff <= 1'b0;
         sig_ff    <= '0;
         wide_ff   <= 1'b0;
         leaf_ff   <= 1'b0;
         left_ff   <= '0;
         shift_ff  <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         size_ff   <= size_in;
         layout_ff <= layout_in;
         sig_ff    <= sig_in;
         wide_ff   <= wide_in;
         leaf_ff   <= leaf_in;
         left_ff   <= left_in;
         shift_ff  <= shift_in;
      end
   end

endmodule

// ===== rtl/rslp_out_buf.sv =====
// Response register with a skid register behind it.
module rslp_out_buf (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  rslp_pkg::rsp_payload_type push_data,
   input  logic                      out_ready,
   output logic                      out_valid,
   output rslp_pkg::rsp_payload_type out_data,
   output logic                      has_space
);
   import rslp_pkg::*;

   logic            main_valid_ff, main_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   rsp_payload_type main_data_ff, main_data_in;
   rsp_payload_type skid_data_ff, skid_data_in;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (!main_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;
   assign has_space = !skid_valid_ff;

endmodule
